### src/scba_pkg.sv
`default_nettype none

package scba_pkg;

    // Geometry defaults
    localparam int CLASS_COUNT_DEF     = 32;
    localparam int BLOCKS_PER_PAGE_DEF = 128;

    // Fixed geometry: both must be powers of two
    localparam int GRAIN_BYTES = 32;
    localparam int PAGE_BYTES  = 4096;
    localparam int GRAIN_W     = $clog2(GRAIN_BYTES);
    localparam int PAGE_W      = $clog2(PAGE_BYTES);

    // Field widths
    localparam int OP_W    = 1;
    localparam int REQ_W   = 11;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;
    localparam int BASE_W  = 32;
    localparam int SIZE_W  = 18;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 32;

    localparam int S_DATA_W = ((REQ_W + ADDR_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ADDR_W + STAT_W + 7) / 8) * 8;

    // Operations
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd3;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_ARENA_BASE = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_ARENA_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] ARENA_SIZE_RST = 18'd131072;

endpackage

`default_nettype wire

### src/size_class_bitmap_allocator_unit.sv
`default_nettype none

// Size-class block allocator. Each input word is an allocate (tuser 0) or a free
// (tuser 1) and yields one result word with the granted address and a status.
// Class c owns the page at arena_base + c*PAGE_BYTES, split into blocks of
// (c+1)*GRAIN_BYTES bytes; its bitmap row lives in a one-port synchronous memory.
// The class row is read at the accepting edge, and the result then passes through
// S_RD (lowest-free search or reciprocal divide), S_MOD (write-back of the row)
// and S_OUT (address assembly into the output register). The block returns to
// S_IDLE before the next word can be taken, so a new word is not accepted while
// one is in flight; the read-modify-write of the row sets this. The block stalls
// only when the output register is still full at the end of an item. Rows come
// out of reset free through per-row valid flags, so no clearing pass is needed
// and words are accepted right after reset.
module size_class_bitmap_allocator_unit #(
    parameter int CLASS_COUNT     = scba_pkg::CLASS_COUNT_DEF,
    parameter int BLOCKS_PER_PAGE = scba_pkg::BLOCKS_PER_PAGE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [10:0] request_bytes, [42:11] block_address, rest zero
    input  wire  [scba_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  wire  [scba_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [31:0] granted_address, [33:32] status, rest zero
    output logic [scba_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input  wire                              i_cfg_wr_en,
    input  wire  [scba_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  wire  [scba_pkg::CFG_D_W-1:0]     i_cfg_wdata
);

    localparam int CW  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int IW  = $clog2(BLOCKS_PER_PAGE);
    localparam int NW  = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int GW  = scba_pkg::GRAIN_W;
    localparam int PGW = scba_pkg::PAGE_W;
    localparam int XW  = PGW - GW;          // page offset in grains
    localparam int K   = XW + CW;           // reciprocal shift
    localparam int MW  = K + 1;
    localparam int PW  = XW + MW;
    localparam int BSW = CW + 1 + GW;       // block size
    localparam int BOW = IW + BSW;          // block offset in page
    localparam int FW  = CW + 1 + PGW;
    localparam int SW  = (FW > scba_pkg::SIZE_W) ? FW : scba_pkg::SIZE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Per-class constants
    logic [NW-1:0] w_blk_n [CLASS_COUNT];
    logic [MW-1:0] w_recip [CLASS_COUNT];

    for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_cls
        localparam int NRAW = scba_pkg::PAGE_BYTES / ((c + 1) * scba_pkg::GRAIN_BYTES);
        localparam int NBLK = (NRAW > BLOCKS_PER_PAGE) ? BLOCKS_PER_PAGE : NRAW;
        localparam int RCP  = ((2 ** K) + c) / (c + 1);
        assign w_blk_n[c] = NW'(NBLK);
        assign w_recip[c] = MW'(RCP);
    end

    logic [1:0]                     r_state;
    logic [scba_pkg::BASE_W-1:0]    r_base;
    logic [scba_pkg::SIZE_W-1:0]    r_arena_size;

    logic [BLOCKS_PER_PAGE-1:0]     r_mem [CLASS_COUNT];
    logic [BLOCKS_PER_PAGE-1:0]     r_rdata;
    logic [CLASS_COUNT-1:0]         r_row_vld;

    logic [scba_pkg::OP_W-1:0]      r_op;
    logic [CW-1:0]                  r_cls;
    logic                           r_bad;
    logic                           r_fits;
    logic [XW-1:0]                  r_xq;
    logic [BLOCKS_PER_PAGE-1:0]     r_row;
    logic [IW-1:0]                  r_idx;
    logic                           r_found;
    logic [PW-1:0]                  r_prod;
    logic [BOW-1:0]                 r_blk_off;
    logic [scba_pkg::STAT_W-1:0]    r_status;
    logic [scba_pkg::M_DATA_W-1:0]  r_out_data;
    logic                           r_out_vld;

    // Input decode
    logic [scba_pkg::REQ_W-1:0]     w_req;
    logic [scba_pkg::ADDR_W-1:0]    w_addr;
    logic [scba_pkg::ADDR_W-1:0]    w_off;
    logic [CW-1:0]                  n_cls;
    logic                           n_bad;
    logic                           n_fits;
    logic                           w_accept;

    assign w_req    = s_axis_tdata[scba_pkg::REQ_W-1:0];
    assign w_addr   = s_axis_tdata[scba_pkg::REQ_W +: scba_pkg::ADDR_W];
    assign w_off    = w_addr - r_base;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (s_axis_tuser == scba_pkg::OP_ALLOC) begin
            n_cls = CW'((w_req - scba_pkg::REQ_W'(1)) >> GW);
            n_bad = (w_req == '0) ||
                    (32'(w_req) > 32'(CLASS_COUNT * scba_pkg::GRAIN_BYTES));
        end else begin
            n_cls = w_off[PGW +: CW];
            n_bad = !(w_off < 32'(CLASS_COUNT * scba_pkg::PAGE_BYTES));
        end
        n_fits = ((SW'(n_cls) + SW'(1)) << PGW) <= SW'(r_arena_size);
    end

    // Row search and arithmetic
    logic [BLOCKS_PER_PAGE-1:0]     w_row;
    logic [NW-1:0]                  w_n;
    logic [IW-1:0]                  w_first;
    logic                           w_any;
    logic [XW-1:0]                  w_q;
    logic [BSW-1:0]                 w_bsize;
    logic                           w_ok;
    logic [BLOCKS_PER_PAGE-1:0]     n_row;
    logic [scba_pkg::STAT_W-1:0]    n_status;

    assign w_row   = r_row_vld[r_cls] ? r_rdata : '0;
    assign w_n     = w_blk_n[r_cls];
    assign w_q     = r_prod[K +: XW];
    assign w_bsize = (BSW'(r_cls) + BSW'(1)) << GW;

    always_comb begin
        w_first = '0;
        w_any   = 1'b0;
        for (int i = BLOCKS_PER_PAGE - 1; i >= 0; i--) begin
            if (!w_row[i] && (32'(i) < 32'(w_n))) begin
                w_first = IW'(i);
                w_any   = 1'b1;
            end
        end
    end

    always_comb begin
        n_row = r_row;
        if (r_op == scba_pkg::OP_ALLOC) begin
            w_ok = !r_bad && r_fits && r_found;
            for (int i = 0; i < BLOCKS_PER_PAGE; i++) begin
                if (32'(r_idx) == 32'(i)) begin
                    n_row[i] = 1'b1;
                end
            end
            if (r_bad) begin
                n_status = scba_pkg::ST_BAD_SIZE;
            end else if (w_ok) begin
                n_status = scba_pkg::ST_OK;
            end else begin
                n_status = scba_pkg::ST_FULL;
            end
        end else begin
            w_ok = !r_bad && r_fits && (32'(w_q) < 32'(w_n));
            for (int i = 0; i < BLOCKS_PER_PAGE; i++) begin
                if (32'(w_q) == 32'(i)) begin
                    n_row[i] = 1'b0;
                end
            end
            n_status = w_ok ? scba_pkg::ST_OK : scba_pkg::ST_BAD_ADDR;
        end
    end

    // Output word
    logic                           w_out_load;
    logic [scba_pkg::M_DATA_W-1:0]  n_out_data;

    assign w_out_load = (r_state == S_OUT) && (!r_out_vld || m_axis_tready);

    always_comb begin
        n_out_data = '0;
        n_out_data[scba_pkg::ADDR_W +: scba_pkg::STAT_W] = r_status;
        if (r_op == scba_pkg::OP_ALLOC && r_status == scba_pkg::ST_OK) begin
            n_out_data[scba_pkg::ADDR_W-1:0] = r_base + (32'(r_cls) << PGW)
                                               + 32'(r_blk_off);
        end
    end

    // Bitmap memory
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= r_mem[n_cls];
        end
        if (r_state == S_MOD && w_ok) begin
            r_mem[r_cls] <= n_row;
        end
    end

    // Config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_arena_size <= scba_pkg::ARENA_SIZE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                scba_pkg::REG_ARENA_BASE: r_base <= i_cfg_wdata;
                scba_pkg::REG_ARENA_SIZE: r_arena_size <= i_cfg_wdata[scba_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_MOD;
                S_MOD: begin
                    if (w_ok) begin
                        r_row_vld[r_cls] <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_cls  <= n_cls;
            r_bad  <= n_bad;
            r_fits <= n_fits;
            r_xq   <= w_off[GW +: XW];
        end
        if (r_state == S_RD) begin
            r_row   <= w_row;
            r_idx   <= w_first;
            r_found <= w_any;
            // floor(x / (c+1)) by rounded-up reciprocal, exact for XW-bit x
            r_prod  <= PW'(r_xq) * PW'(w_recip[r_cls]);
        end
        if (r_state == S_MOD) begin
            r_status  <= n_status;
            r_blk_off <= BOW'(r_idx) * BOW'(w_bsize);
        end
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import scba_pkg::*;

    localparam int CLASSES      = CLASS_COUNT_DEF;
    localparam int BLOCKS       = BLOCKS_PER_PAGE_DEF;
    localparam int ARENA_SPAN   = CLASSES * PAGE_BYTES;
    localparam int SETTLE_CYC   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_PRINTS   = 50;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
    } grant_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_A_W-1:0]    i_cfg_addr;
    logic [CFG_D_W-1:0]    i_cfg_wdata;

    // predictor state
    logic [BLOCKS-1:0]     used_map [CLASSES];
    logic [BASE_W-1:0]     arena_base_r;
    logic [SIZE_W-1:0]     arena_size_r;

    grant_t                expected_grants [$];
    logic [ADDR_W-1:0]     live_blocks [$];

    bit src_gaps;
    bit sink_stalls;
    bit sink_hold_req;

    int n_mismatch;
    int n_words;
    int n_grants;
    int n_full;
    int n_bad_size;
    int n_frees_ok;
    int n_bad_addr;

    size_class_bitmap_allocator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned blocks_of(input int unsigned cls);
        int unsigned n;
        n = PAGE_BYTES / ((cls + 1) * GRAIN_BYTES);
        return (n > BLOCKS) ? BLOCKS : n;
    endfunction

    function automatic bit class_fits(input int unsigned cls);
        return ((cls + 1) * PAGE_BYTES) <= int'(arena_size_r);
    endfunction

    // Updates the bitmaps and returns what the block should answer.
    function automatic grant_t predict_grant(input logic [OP_W-1:0] op,
                                             input logic [REQ_W-1:0] req,
                                             input logic [ADDR_W-1:0] addr);
        grant_t      r;
        int unsigned cls, bsize, nblk, i, page_ofs, idx;
        logic [31:0] off;
        r.addr   = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (req == 0 || req > CLASSES * GRAIN_BYTES) begin
                r.status = ST_BAD_SIZE;
            end else begin
                cls      = (int'(req) + GRAIN_BYTES - 1) / GRAIN_BYTES - 1;
                bsize    = (cls + 1) * GRAIN_BYTES;
                nblk     = blocks_of(cls);
                r.status = ST_FULL;
                if (class_fits(cls)) begin
                    for (i = 0; i < nblk && r.status != ST_OK; i++) begin
                        if (!used_map[cls][i]) begin
                            used_map[cls][i] = 1'b1;
                            r.addr   = arena_base_r + 32'(cls * PAGE_BYTES) + 32'(i * bsize);
                            r.status = ST_OK;
                        end
                    end
                end
            end
        end else begin
            off      = addr - arena_base_r;
            r.status = ST_BAD_ADDR;
            if (off < ARENA_SPAN) begin
                cls      = off / PAGE_BYTES;
                page_ofs = off % PAGE_BYTES;
                bsize    = (cls + 1) * GRAIN_BYTES;
                idx      = page_ofs / bsize;
                if (class_fits(cls) && idx < blocks_of(cls)) begin
                    used_map[cls][idx] = 1'b0;
                    r.status = ST_OK;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                             input logic [ADDR_W-1:0] addr);
        grant_t want;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_DATA_W - REQ_W - ADDR_W){1'b0}}, addr, req};
        do @(posedge i_clk); while (!s_axis_tready);
        want = predict_grant(op, req, addr);
        expected_grants.push_back(want);
        n_words++;
        if (op == OP_ALLOC) begin
            if (want.status == ST_OK) begin
                n_grants++;
                live_blocks.push_back(want.addr);
            end else if (want.status == ST_FULL) begin
                n_full++;
            end else begin
                n_bad_size++;
            end
        end else if (want.status == ST_OK) begin
            n_frees_ok++;
        end else begin
            n_bad_addr++;
        end
    endtask

    // source goes quiet, every result comes back, then the pipe is left to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_ARENA_BASE) begin
            arena_base_r = val;
            live_blocks.delete();
        end else begin
            arena_size_r = val[SIZE_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic test_size_edges();
        send_word(OP_ALLOC, 11'd0, 32'h0);
        send_word(OP_ALLOC, 11'd1, 32'hFFFF_FFFF);
        send_word(OP_ALLOC, 11'd32, 32'h0);
        send_word(OP_ALLOC, 11'd33, 32'h0);
        send_word(OP_ALLOC, 11'd1024, 32'h0);
        send_word(OP_ALLOC, 11'd1025, 32'h0);
        send_word(OP_ALLOC, 11'd2047, 32'h0);
        send_word(OP_ALLOC, 11'd993, 32'h0);
        // inside the second class-0 block, not at its start
        send_word(OP_FREE, 11'h7FF, 32'h25);
        send_word(OP_ALLOC, 11'd20, 32'h0);
        send_word(OP_FREE, 11'd0, 32'h20);
        send_word(OP_FREE, 11'd0, 32'h20);
        // tail of the 96-byte page past its last whole block
        send_word(OP_FREE, 11'd0, 32'(2 * PAGE_BYTES + 4032));
        send_word(OP_FREE, 11'd0, 32'(ARENA_SPAN));
        send_word(OP_FREE, 11'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_class_full();
        repeat (5) send_word(OP_ALLOC, 11'd1000, 32'h0);
        send_word(OP_FREE, 11'd0, 32'(31 * PAGE_BYTES + 1024 + 500));
        send_word(OP_ALLOC, 11'd1000, 32'h0);
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(REG_ARENA_SIZE, 32'd0);
        send_word(OP_ALLOC, 11'd1, 32'h0);
        send_word(OP_FREE, 11'd0, 32'h0);
        drain();
        write_reg(REG_ARENA_SIZE, 32'(5 * PAGE_BYTES));
        send_word(OP_ALLOC, 11'd160, 32'h0);
        send_word(OP_ALLOC, 11'd161, 32'h0);
        send_word(OP_FREE, 11'd0, 32'(5 * PAGE_BYTES));
        send_word(OP_FREE, 11'd0, 32'(4 * PAGE_BYTES));
        drain();
        // region straddles the top of the address space
        write_reg(REG_ARENA_BASE, 32'hFFFF_F000);
        write_reg(REG_ARENA_SIZE, 32'h0003_FFFF);
        send_word(OP_ALLOC, 11'd1, 32'h0);
        send_word(OP_ALLOC, 11'd64, 32'h0);
        send_word(OP_FREE, 11'd0, 32'h0000_0005);
        drain();
        write_reg(REG_ARENA_BASE, 32'hFFFF_FFFF);
        write_reg(REG_ARENA_SIZE, 32'(ARENA_SPAN));
        send_word(OP_ALLOC, 11'd1024, 32'h0);
        send_word(OP_FREE, 11'd0, 32'hFFFF_FFFE);
        drain();
    endtask

    // sink stops for a long stretch while words keep coming
    task automatic test_backpressure();
        bit keep_gaps;
        keep_gaps     = src_gaps;
        src_gaps      = 1'b0;
        sink_hold_req = 1'b1;
        repeat (30) send_word(OP_ALLOC, 11'($urandom_range(1, 1024)), $urandom);
        drain();
        src_gaps = keep_gaps;
    endtask

    task automatic test_random_traffic(input logic [CFG_D_W-1:0] base,
                                       input logic [CFG_D_W-1:0] size, input int count);
        int                k, pick, sel;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        drain();
        write_reg(REG_ARENA_BASE, base);
        write_reg(REG_ARENA_SIZE, size);
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            req  = 11'($urandom_range(1, 1024));
            addr = $urandom;
            if (pick < 40) begin
                // lean on the big classes so they run full often
                if ($urandom_range(0, 1) == 1)
                    req = 11'($urandom_range(737, 1024));
                send_word(OP_ALLOC, req, addr);
            end else if (pick < 75 && live_blocks.size() > 0) begin
                sel  = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[sel];
                live_blocks.delete(sel);
                if ($urandom_range(0, 3) == 0)
                    addr = addr + 32'($urandom_range(1, GRAIN_BYTES - 1));
                send_word(OP_FREE, 11'($urandom), addr);
            end else if (pick < 88) begin
                addr = arena_base_r + 32'($urandom_range(0, 2 * ARENA_SPAN));
                send_word(OP_FREE, req, addr);
            end else if (pick < 94) begin
                req = ($urandom_range(0, 1) == 1) ? 11'd0 : 11'($urandom_range(1025, 2047));
                send_word(OP_ALLOC, req, addr);
            end else begin
                send_word($urandom_range(0, 1) == 1 ? OP_FREE : OP_ALLOC, 11'($urandom), addr);
            end
        end
    endtask

    initial begin : sink_pacing
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        grant_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_grants.size() == 0) begin
                flag_mismatch($sformatf("result word %h with nothing pending", m_axis_tdata));
            end else begin
                want = expected_grants.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] !== want.addr)
                    flag_mismatch($sformatf("granted_address %h, want %h",
                                            m_axis_tdata[ADDR_W-1:0], want.addr));
                if (m_axis_tdata[ADDR_W +: STAT_W] !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            m_axis_tdata[ADDR_W +: STAT_W], want.status));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int c;
        for (c = 0; c < CLASSES; c++) used_map[c] = '0;
        arena_base_r  = '0;
        arena_size_r  = ARENA_SIZE_RST;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        sink_hold_req = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_ALLOC;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_addr    <= REG_ARENA_BASE;
        i_cfg_wdata   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_size_edges();
        test_class_full();
        test_config_extremes();
        test_backpressure();
        test_random_traffic($urandom, 32'(ARENA_SPAN), 180);
        test_random_traffic(32'h8000_0000, 32'($urandom_range(0, ARENA_SPAN)), 180);
        test_random_traffic(32'hFFFF_0000, 32'(ARENA_SPAN), 180);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_random_traffic($urandom, 32'(ARENA_SPAN), 180);
        drain();

        $display("Covered %0d words: %0d grants, %0d full/no room, %0d bad sizes",
                 n_words, n_grants, n_full, n_bad_size);
        $display("Frees: %0d accepted, %0d rejected; %0d mismatches",
                 n_frees_ok, n_bad_addr, n_mismatch);
        if (n_mismatch == 0 && expected_grants.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/scba_pkg.sv
src/size_class_bitmap_allocator_unit.sv
sim/tb_top.sv
